// ----- design/gh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and GF(2^128) constant tables for the GHASH tag engine.
package gh_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;

    typedef logic [BLOCK_W-1:0]                 t_block;
    typedef logic [BLOCK_W-1:0][BLOCK_W-1:0]    t_htab;
    typedef logic [2*BLOCK_W-2:0][BLOCK_W-1:0]  t_xpow;

    // request codes carried in tuser
    localparam logic [1:0] REQ_AAD    = 2'd0;
    localparam logic [1:0] REQ_TEXT   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
    localparam logic [1:0] CFG_MASK_HIGH = 2'd2;
    localparam logic [1:0] CFG_MASK_LOW  = 2'd3;

    localparam logic [4:0] MAX_BYTES = 5'd16;

    // reduction constant: 0xE1 followed by 120 zero bits
    localparam t_block RED_POLY = {8'hE1, 120'd0};

    // multiply by x in GCM bit order (MSB is the x^0 coefficient)
    function automatic t_block gh_mulx(input t_block v);
        t_block r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ RED_POLY;
        end
        return r;
    endfunction

    // x^k mod P for every k a product of two degree-127 terms can reach
    function automatic t_xpow gh_xpow_gen();
        t_xpow  t;
        t_block v;
        v = {1'b1, {(BLOCK_W-1){1'b0}}};
        for (int k = 0; k < 2*BLOCK_W-1; k++) begin
            t[k] = v;
            v = gh_mulx(v);
        end
        return t;
    endfunction

    localparam t_xpow XPOW = gh_xpow_gen();

    // row i holds H * x^i, each row an independent sum of constant terms
    function automatic t_htab gh_key_table(input t_block h);
        t_htab t;
        for (int i = 0; i < BLOCK_W; i++) begin
            t[i] = '0;
            for (int j = 0; j < BLOCK_W; j++) begin
                if (h[BLOCK_W-1-j]) begin
                    t[i] = t[i] ^ XPOW[i+j];
                end
            end
        end
        return t;
    endfunction

endpackage

// ----- design/gcm_ghash_tag_top.sv -----
`timescale 1ns / 1ps
// GHASH authentication tag engine, top level.
//
// Input stream (s_axis): one word per 128-bit AAD or ciphertext block, or a
// finish request. tuser selects the kind: 0 AAD, 1 ciphertext, 2 finish,
// 3 is dropped. Absorb words fold (acc xor block) * H into the accumulator
// and add 8 * valid_bytes (capped at 16 bytes) to the AAD or text bit count.
// A finish word computes ((acc xor lenA||lenC) * H) xor E(K,J0), sends it
// as one tag word on m_axis and clears the accumulator and both counts.
// Throughput: one word per cycle while s_axis tready is high. The multiply
// is a combinational xor tree over a 128-row table of H * x^i, rebuilt when
// a key half is written, so the accumulator loads each product as its word
// is accepted. The tag is registered in the output or skid entry.
// Output stall: a two-entry output stage (output register plus skid)
// decouples the sides; s_axis tready drops only while both entries hold a
// tag. Reset clears key, mask, table, accumulator, counts and output valid flags.
// Issue configuration writes (i_cfg_we/index/wdata) only while no word is in flight.
module gcm_ghash_tag_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // write port for hash key and tag mask halves
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_wdata,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tdata: block_high[63:0], block_low[127:64], valid_bytes[132:128], zero pad
    input  logic [135:0]  i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]    i_s_axis_tuser,
    // output stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tdata: tag_high[63:0], tag_low[127:64]
    output logic [127:0]  o_m_axis_tdata
);
    import gh_pkg::*;

    t_block       r_key;
    t_block       r_mask;
    t_htab        r_htab;
    t_block       r_acc;
    logic [63:0]  r_aad_bits;
    logic [63:0]  r_text_bits;
    logic         r_out_valid;
    t_block       r_out_tag;
    logic         r_skid_valid;
    t_block       r_skid_tag;

    t_block       n_key;
    logic         key_write;
    logic         accept;
    logic         is_absorb;
    logic         is_finish;
    logic [4:0]   nbytes;
    logic [63:0]  add_bits;
    t_block       blk;
    t_block       mul_x;
    t_block       mul_z;
    t_block       tag;
    logic         push;
    logic         out_free;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_absorb = (i_s_axis_tuser == REQ_AAD) || (i_s_axis_tuser == REQ_TEXT);
    assign is_finish = (i_s_axis_tuser == REQ_FINISH);
    assign nbytes    = (i_s_axis_tdata[132:128] > MAX_BYTES) ? MAX_BYTES
                                                             : i_s_axis_tdata[132:128];
    assign add_bits  = {56'd0, nbytes, 3'd0};
    assign blk       = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
    assign mul_x     = is_finish ? (r_acc ^ {r_aad_bits, r_text_bits}) : (r_acc ^ blk);
    assign tag       = mul_z ^ r_mask;
    assign push      = accept && is_finish;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    gh_mul u_mul (
        .i_htab (r_htab),
        .i_x    (mul_x),
        .o_z    (mul_z)
    );

    always_comb begin
        key_write = 1'b0;
        n_key     = r_key;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: begin
                    key_write = 1'b1;
                    n_key     = {i_cfg_wdata, r_key[63:0]};
                end
                CFG_KEY_LOW: begin
                    key_write = 1'b1;
                    n_key     = {r_key[127:64], i_cfg_wdata};
                end
                default: begin
                    key_write = 1'b0;
                    n_key     = r_key;
                end
            endcase
        end
    end

    // key, mask and key table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mask <= '0;
            r_htab <= '0;
        end else if (i_cfg_we) begin
            if (key_write) begin
                r_key  <= n_key;
                r_htab <= gh_key_table(n_key);
            end
            if (i_cfg_index == CFG_MASK_HIGH) begin
                r_mask[127:64] <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_MASK_LOW) begin
                r_mask[63:0] <= i_cfg_wdata;
            end
        end
    end

    // accumulator and length counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_aad_bits  <= '0;
            r_text_bits <= '0;
        end else if (accept) begin
            if (is_finish) begin
                r_acc       <= '0;
                r_aad_bits  <= '0;
                r_text_bits <= '0;
            end else if (is_absorb) begin
                r_acc <= mul_z;
                if (i_s_axis_tuser == REQ_AAD) begin
                    r_aad_bits <= r_aad_bits + add_bits;
                end else begin
                    r_text_bits <= r_text_bits + add_bits;
                end
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_tag <= r_skid_tag;
            end else if (push) begin
                r_out_tag <= tag;
            end
        end else if (push) begin
            r_skid_tag <= tag;
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_tag[63:0], r_out_tag[127:64]};

endmodule

// ----- design/gh_mul.sv -----
`timescale 1ns / 1ps
// GF(2^128) multiplier against a precomputed table of H * x^i.
module gh_mul (
    input  gh_pkg::t_htab  i_htab,
    input  gh_pkg::t_block i_x,
    output gh_pkg::t_block o_z
);
    import gh_pkg::*;

    // each set coefficient of x selects one table row; xor them all
    always_comb begin
        o_z = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            if (i_x[BLOCK_W-1-i]) begin
                o_z = o_z ^ i_htab[i];
            end
        end
    end

endmodule

// ----- design/gh_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the GHASH tag engine, bound to the top level.
module gh_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    input  logic          o_s_axis_tready,
    input  logic [1:0]    i_s_axis_tuser,
    input  logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  logic [127:0]  o_m_axis_tdata
);
    import gh_pkg::*;

    logic finish_accept;
    assign finish_accept = i_s_axis_tvalid && o_s_axis_tready
                           && (i_s_axis_tuser == REQ_FINISH);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output stage not empty after reset");

    // a stalled tag word holds its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("tag changed while stalled");

    // a tag only appears after a finish word
    a_tag_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(finish_accept))
        else $error("tag without finish request");

    // input back-pressure only while a tag is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind gcm_ghash_tag_top gh_checker u_gh_checker (.*);
